// ===== src/cpbw_pkg.sv =====
// cpbw_pkg: action and outcome codes, configuration register indexes and
// reset values shared by the channel interfaces and the blend writer.
// No dependencies.
package cpbw_pkg;

  typedef enum logic [1:0] {
    ACT_OPAQUE = 2'd0,
    ACT_KEYED  = 2'd1,
    ACT_BLEND  = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    OUT_WRITTEN = 2'd0,
    OUT_CLIPPED = 2'd1,
    OUT_SKIPPED = 2'd2,
    OUT_READ    = 2'd3
  } outcome_t;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP_LEFT   = 3'd0,
    REG_CLIP_TOP    = 3'd1,
    REG_CLIP_WIDTH  = 3'd2,
    REG_CLIP_HEIGHT = 3'd3,
    REG_KEY_COLOR   = 3'd4
  } cfg_reg_t;

  localparam logic [7:0]  CLIP_ORIGIN_RESET = 8'd0;
  localparam logic [8:0]  CLIP_SIZE_RESET   = 9'd256;
  localparam logic [31:0] KEY_COLOR_RESET   = 32'h0000_0000;
  localparam logic [7:0]  ALPHA_OPAQUE      = 8'hFF;
  localparam logic [15:0] BLEND_ROUND       = 16'h0080;

endpackage

// ===== src/cpbw_item_if.sv =====
// cpbw_item_if: pixel operation channel (valid/ready plus operation fields).
// Depends on cpbw_pkg.
interface cpbw_item_if;
  logic                   valid;
  logic                   ready;
  cpbw_pkg::action_t      action;
  logic signed [15:0]     dest_x;
  logic signed [15:0]     dest_y;
  logic [31:0]            pixel_color;

  modport source(output valid, action, dest_x, dest_y, pixel_color, input ready);
  modport sink(input valid, action, dest_x, dest_y, pixel_color, output ready);
endinterface

// ===== src/cpbw_result_if.sv =====
// cpbw_result_if: result channel (valid/ready plus stored or read value).
// Depends on cpbw_pkg.
interface cpbw_result_if;
  logic                 valid;
  logic                 ready;
  logic [31:0]          pixel_value;
  cpbw_pkg::outcome_t   outcome;

  modport source(output valid, pixel_value, outcome, input ready);
  modport sink(input valid, pixel_value, outcome, output ready);
endinterface

// ===== src/cpbw_cfg_if.sv =====
// cpbw_cfg_if: configuration write channel (valid/ready, index, data).
// Depends on cpbw_pkg.
interface cpbw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cpbw_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/clipped_pixel_blend_writer.sv =====
// clipped_pixel_blend_writer: clipped ARGB8888 framebuffer writer with colour
// key, alpha blend and read-back. Depends on cpbw_pkg and the cpbw_*_if files.
//
//   channel  modport  carries                                  transfer when
//   item     sink     action, dest_x, dest_y, pixel_color      valid && ready
//   result   source   pixel_value, outcome                     valid && ready
//   cfg      sink     index (0..4), data                       valid && ready
//
// Each item passes through accept and decode, framebuffer read, then blend /
// write-back / result load. The framebuffer read-modify-write through the one
// registered-read memory sets that sequence; items do not overlap.
// Reset clears control and configuration only; framebuffer contents are
// undefined until written and there is no clearing pass.
// A stalled result holds in the output register; the next item is still
// accepted and waits in the execute step until the register frees.
module clipped_pixel_blend_writer #(
  parameter int FB_WIDTH  = 256,
  parameter int FB_HEIGHT = 256
) (
  input  logic           clk,
  input  logic           rst,
  cpbw_item_if.sink      item,
  cpbw_cfg_if.sink       cfg,
  cpbw_result_if.source  result
);

  localparam int FB_DEPTH = FB_WIDTH * FB_HEIGHT;
  localparam int ADDR_W   = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
  localparam int X_W      = (FB_WIDTH > 1) ? $clog2(FB_WIDTH) : 1;
  localparam int Y_W      = (FB_HEIGHT > 1) ? $clog2(FB_HEIGHT) : 1;

  localparam logic [7:0] ALPHA_MAX = cpbw_pkg::ALPHA_OPAQUE;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_t;

  // What the execute step does, settled at acceptance.
  typedef enum logic [2:0] {
    OP_CLIP,
    OP_SKIP,
    OP_WRITE,
    OP_BLEND,
    OP_READ
  } op_t;

  // Per-lane blend. Red and blue round with +128; green's rounding term
  // falls below the lane in the packed form, so green truncates.
  function automatic logic [31:0] blend_px(input logic [31:0] s, input logic [31:0] d);
    logic [7:0]  a;
    logic [7:0]  ia;
    logic [15:0] r_sum;
    logic [15:0] g_sum;
    logic [15:0] b_sum;
    a     = s[31:24];
    ia    = ALPHA_MAX - a;
    r_sum = 16'(s[23:16]) * 16'(a) + 16'(d[23:16]) * 16'(ia) + cpbw_pkg::BLEND_ROUND;
    g_sum = 16'(s[15:8]) * 16'(a) + 16'(d[15:8]) * 16'(ia);
    b_sum = 16'(s[7:0]) * 16'(a) + 16'(d[7:0]) * 16'(ia) + cpbw_pkg::BLEND_ROUND;
    return {8'h00, r_sum[15:8], g_sum[15:8], b_sum[15:8]};
  endfunction

  // configuration registers
  logic [7:0]  clip_left;
  logic [7:0]  clip_top;
  logic [8:0]  clip_width;
  logic [8:0]  clip_height;
  logic [31:0] chroma_key;

  // control
  state_t      state;
  op_t         op;
  logic        out_valid;

  // payload
  logic [ADDR_W-1:0] addr;
  logic [31:0]       src;
  logic [31:0]       rdata;
  logic [31:0]       out_value;
  cpbw_pkg::outcome_t out_code;

  logic [31:0] fb_mem [FB_DEPTH];

  // decode of the offered item
  logic        on_surface;
  logic        in_clip;
  logic [14:0] x_mag;
  logic [14:0] y_mag;
  logic [9:0]  clip_right;
  logic [9:0]  clip_bottom;
  op_t         op_next;
  logic [ADDR_W-1:0] addr_next;

  logic        take;
  logic        exec_go;
  logic        mem_we;
  logic [31:0] exec_value;
  cpbw_pkg::outcome_t exec_code;

  assign take    = item.valid && item.ready;
  assign exec_go = (state == S_EXEC) && (!out_valid || result.ready);

  assign x_mag       = item.dest_x[14:0];
  assign y_mag       = item.dest_y[14:0];
  assign clip_right  = 10'(clip_left) + 10'(clip_width);
  assign clip_bottom = 10'(clip_top) + 10'(clip_height);

  assign on_surface = !item.dest_x[15] && (x_mag < 15'(FB_WIDTH)) &&
                      !item.dest_y[15] && (y_mag < 15'(FB_HEIGHT));
  // only meaningful when on_surface (coordinates non-negative)
  assign in_clip = (15'(clip_left) <= x_mag) && (x_mag < 15'(clip_right)) &&
                   (15'(clip_top) <= y_mag) && (y_mag < 15'(clip_bottom));

  assign addr_next = ADDR_W'(ADDR_W'(item.dest_y[Y_W-1:0]) * ADDR_W'(FB_WIDTH)) +
                     ADDR_W'(item.dest_x[X_W-1:0]);

  // Clip test comes before key and alpha tests; reads test only the surface.
  always_comb begin
    if (item.action == cpbw_pkg::ACT_READ) begin
      op_next = on_surface ? OP_READ : OP_CLIP;
    end else if (!on_surface || !in_clip) begin
      op_next = OP_CLIP;
    end else if (item.action == cpbw_pkg::ACT_KEYED && item.pixel_color == chroma_key) begin
      op_next = OP_SKIP;
    end else if (item.action == cpbw_pkg::ACT_BLEND) begin
      if (item.pixel_color[31:24] == 8'h00) begin
        op_next = OP_SKIP;
      end else if (item.pixel_color[31:24] == ALPHA_MAX) begin
        op_next = OP_WRITE;
      end else begin
        op_next = OP_BLEND;
      end
    end else begin
      op_next = OP_WRITE;
    end
  end

  always_comb begin
    case (op)
      OP_CLIP: begin
        exec_value = 32'h0;
        exec_code  = cpbw_pkg::OUT_CLIPPED;
      end
      OP_SKIP: begin
        exec_value = 32'h0;
        exec_code  = cpbw_pkg::OUT_SKIPPED;
      end
      OP_WRITE: begin
        exec_value = src;
        exec_code  = cpbw_pkg::OUT_WRITTEN;
      end
      OP_BLEND: begin
        exec_value = blend_px(src, rdata);
        exec_code  = cpbw_pkg::OUT_WRITTEN;
      end
      OP_READ: begin
        exec_value = rdata;
        exec_code  = cpbw_pkg::OUT_READ;
      end
      default: begin
        exec_value = 32'h0;
        exec_code  = cpbw_pkg::OUT_CLIPPED;
      end
    endcase
  end

  assign mem_we = exec_go && (op == OP_WRITE || op == OP_BLEND);

  // Framebuffer: one write port, one registered read port. Items do not
  // overlap, so the write-back always lands before the next read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      fb_mem[addr] <= exec_value;
    end
    if (state == S_READ) begin
      rdata <= fb_mem[addr];
    end
  end

  // sequencer and output register; a load in the same cycle as a transfer
  // out keeps the register full
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (exec_go) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item payload and result payload
  always_ff @(posedge clk) begin
    if (take) begin
      op   <= op_next;
      addr <= addr_next;
      src  <= item.pixel_color;
    end
    if (exec_go) begin
      out_value <= exec_value;
      out_code  <= exec_code;
    end
  end

  // configuration writes; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= cpbw_pkg::CLIP_ORIGIN_RESET;
      clip_top    <= cpbw_pkg::CLIP_ORIGIN_RESET;
      clip_width  <= cpbw_pkg::CLIP_SIZE_RESET;
      clip_height <= cpbw_pkg::CLIP_SIZE_RESET;
      chroma_key  <= cpbw_pkg::KEY_COLOR_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        cpbw_pkg::REG_CLIP_LEFT:   clip_left   <= cfg.data[7:0];
        cpbw_pkg::REG_CLIP_TOP:    clip_top    <= cfg.data[7:0];
        cpbw_pkg::REG_CLIP_WIDTH:  clip_width  <= cfg.data[8:0];
        cpbw_pkg::REG_CLIP_HEIGHT: clip_height <= cfg.data[8:0];
        cpbw_pkg::REG_KEY_COLOR:   chroma_key  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  assign item.ready         = (state == S_IDLE);
  assign cfg.ready          = 1'b1;
  assign result.valid       = out_valid;
  assign result.pixel_value = out_value;
  assign result.outcome     = out_code;

endmodule

// ===== sim/cpbw_scoreboard_pkg.sv =====
// cpbw_scoreboard_pkg: framebuffer predictor and result scoreboard for the
// clipped pixel blend writer testbench. Depends on cpbw_pkg.
package cpbw_scoreboard_pkg;
  import cpbw_pkg::*;

  localparam int FB_W = 256;
  localparam int FB_H = 256;

  typedef struct packed {
    logic [31:0] value;
    outcome_t    outcome;
  } pixel_result_t;

  class pixel_scoreboard;
    logic [31:0]   fb_model [0:FB_W*FB_H-1];
    bit            written [0:FB_W*FB_H-1];
    logic [7:0]    clip_left;
    logic [7:0]    clip_top;
    logic [8:0]    clip_width;
    logic [8:0]    clip_height;
    logic [31:0]   chroma_key;
    pixel_result_t expected_pixels [$];
    int            errors;

    function new();
      clip_left   = CLIP_ORIGIN_RESET;
      clip_top    = CLIP_ORIGIN_RESET;
      clip_width  = CLIP_SIZE_RESET;
      clip_height = CLIP_SIZE_RESET;
      chroma_key  = KEY_COLOR_RESET;
      errors      = 0;
    endfunction

    function bit on_fb(int x, int y);
      return x >= 0 && x < FB_W && y >= 0 && y < FB_H;
    endfunction

    function bit in_clip_rect(int x, int y);
      return x >= int'(clip_left) && x < int'(clip_left) + int'(clip_width) &&
             y >= int'(clip_top) && y < int'(clip_top) + int'(clip_height);
    endfunction

    // a read must not land on a never-written entry
    function bit read_defined(int x, int y);
      return !on_fb(x, y) || written[y*FB_W + x];
    endfunction

    // a partial blend must not use a never-written entry as destination
    function bit blend_defined(int x, int y);
      return !on_fb(x, y) || !in_clip_rect(x, y) || written[y*FB_W + x];
    endfunction

    // red and blue round with +128; green truncates (its rounding term
    // drops below the lane in the packed form)
    function logic [31:0] mix_channels(logic [31:0] s, logic [31:0] d, logic [7:0] a);
      logic [31:0] m;
      logic [16:0] acc;
      int          lane;
      m = '0;
      for (lane = 0; lane < 3; lane++) begin
        acc = s[lane*8 +: 8] * a + d[lane*8 +: 8] * (8'd255 - a) +
              ((lane == 1) ? 17'd0 : 17'd128);
        m[lane*8 +: 8] = acc[15:8];
      end
      return m;
    endfunction

    function pixel_result_t predict_pixel_op(action_t act, int x, int y, logic [31:0] src);
      pixel_result_t r;
      int            idx;
      logic [7:0]    a;
      r.value = '0;
      idx = 0;
      a = src[31:24];
      if (on_fb(x, y)) idx = y*FB_W + x;
      if (act == ACT_READ) begin
        if (on_fb(x, y)) begin
          r.value   = fb_model[idx];
          r.outcome = OUT_READ;
        end else begin
          r.outcome = OUT_CLIPPED;
        end
      end else if (!on_fb(x, y) || !in_clip_rect(x, y)) begin
        r.outcome = OUT_CLIPPED;
      end else if (act == ACT_KEYED && src == chroma_key) begin
        r.outcome = OUT_SKIPPED;
      end else if (act == ACT_BLEND && a == 8'h00) begin
        r.outcome = OUT_SKIPPED;
      end else begin
        if (act == ACT_BLEND && a != ALPHA_OPAQUE) r.value = mix_channels(src, fb_model[idx], a);
        else r.value = src;
        fb_model[idx] = r.value;
        written[idx]  = 1'b1;
        r.outcome     = OUT_WRITTEN;
      end
      return r;
    endfunction

    function void set_reg(cfg_reg_t r, logic [31:0] d);
      case (r)
        REG_CLIP_LEFT:   clip_left   = d[7:0];
        REG_CLIP_TOP:    clip_top    = d[7:0];
        REG_CLIP_WIDTH:  clip_width  = d[8:0];
        REG_CLIP_HEIGHT: clip_height = d[8:0];
        REG_KEY_COLOR:   chroma_key  = d;
        default: ;
      endcase
    endfunction

    function void note_op(action_t act, logic signed [15:0] x, logic signed [15:0] y,
                          logic [31:0] src);
      expected_pixels.push_back(predict_pixel_op(act, x, y, src));
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    task report(string msg);
      if (errors < 100) $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [31:0] value, outcome_t outcome);
      pixel_result_t e;
      if (expected_pixels.size() == 0) begin
        report($sformatf("result %h/%0d with nothing outstanding", value, outcome));
      end else begin
        e = expected_pixels.pop_front();
        if (value !== e.value)
          report($sformatf("pixel_value %h, want %h", value, e.value));
        if (outcome !== e.outcome)
          report($sformatf("outcome %0d, want %0d", outcome, e.outcome));
      end
    endtask
  endclass

endpackage

// ===== sim/tb_clipped_pixel_blend_writer.sv =====
// tb_clipped_pixel_blend_writer: directed and random pixel operations across
// several clip/key settings and idle patterns. Depends on cpbw_pkg, the cpbw
// interfaces, cpbw_scoreboard_pkg and clipped_pixel_blend_writer.
module tb_clipped_pixel_blend_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import cpbw_pkg::*;
  import cpbw_scoreboard_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no transfer at all
  localparam int CHUNK_OPS   = 42;
  localparam int NUM_PHASES  = 8;

  // idle patterns
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_SENDER = 1;
  localparam int IDLE_SINK   = 2;
  localparam int IDLE_BOTH   = 3;

  logic clk;
  logic rst;

  cpbw_item_if   item_ch ();
  cpbw_cfg_if    cfg_ch ();
  cpbw_result_if res_ch ();

  clipped_pixel_blend_writer #(
    .FB_WIDTH  (FB_W),
    .FB_HEIGHT (FB_H)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .cfg    (cfg_ch),
    .result (res_ch)
  );

  pixel_scoreboard sb;

  int src_idle_pct;
  int snk_stall_pct;
  int hold_left;      // long receiver hold-off, counted down by the receiver
  int quiet_cycles;
  int hot_x, hot_y;   // small window hammered for read-modify-write hazards

  always #6 clk = ~clk;

  // Receiver: result ready changes on the falling edge only.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_ch.ready = 1'b0;
      hold_left--;
    end else begin
      res_ch.ready = ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Monitor and watchdog: every transfer is sampled at the rising edge.
  // Results are checked before the same-edge item is noted, so a spurious
  // result can never consume a fresh expectation.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.pixel_value, res_ch.outcome);
      if (cfg_ch.valid && cfg_ch.ready)
        sb.set_reg(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
      if (item_ch.valid && item_ch.ready)
        sb.note_op(item_ch.action, item_ch.dest_x, item_ch.dest_y, item_ch.pixel_color);

      if ((res_ch.valid && res_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
          (item_ch.valid && item_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("TIMEOUT: no transfer for %0d cycles", STALL_LIMIT);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  task automatic set_idling(int mode);
    case (mode)
      IDLE_NONE:   begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      IDLE_SENDER: begin src_idle_pct = 51; snk_stall_pct = 0;  end
      IDLE_SINK:   begin src_idle_pct = 0;  snk_stall_pct = 51; end
      default:     begin src_idle_pct = 7;  snk_stall_pct = 7;  end
    endcase
  endtask

  // Move to the falling edge, with random sender gaps first.
  task automatic pace();
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
  endtask

  // Offer one operation and hold it until the transfer.
  task automatic drive_op(action_t a, logic signed [15:0] x, logic signed [15:0] y,
                          logic [31:0] c);
    item_ch.valid       = 1'b1;
    item_ch.action      = a;
    item_ch.dest_x      = x;
    item_ch.dest_y      = y;
    item_ch.pixel_color = c;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic op(action_t a, logic signed [15:0] x, logic signed [15:0] y,
                    logic [31:0] c);
    pace();
    drive_op(a, x, y, c);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [31:0] d);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = r;
    cfg_ch.data  = d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Drop valid, then wait for every outstanding result.
  task automatic drain();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_clip(int l, int t, int w, int h, logic [31:0] key);
    write_reg(REG_CLIP_LEFT, 32'(l));
    write_reg(REG_CLIP_TOP, 32'(t));
    write_reg(REG_CLIP_WIDTH, 32'(w));
    write_reg(REG_CLIP_HEIGHT, 32'(h));
    write_reg(REG_KEY_COLOR, key);
  endtask

  // Random operation; called at the falling edge so the scoreboard already
  // holds every earlier transfer when the legality tests run.
  task automatic gen_op(output action_t a, output logic signed [15:0] x,
                        output logic signed [15:0] y, output logic [31:0] c);
    int pick;
    int l, t, w, h;
    l = int'(sb.clip_left);
    t = int'(sb.clip_top);
    w = int'(sb.clip_width);
    h = int'(sb.clip_height);
    c = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      x = 16'(hot_x + $urandom_range(0, 5));
      y = 16'(hot_y + $urandom_range(0, 5));
    end else if (pick < 70) begin
      // around the clip edges, just inside and just outside
      case ($urandom_range(0, 3))
        0: x = 16'(l - 1);
        1: x = 16'(l);
        2: x = 16'(l + w - 1);
        default: x = 16'(l + w);
      endcase
      case ($urandom_range(0, 3))
        0: y = 16'(t - 1);
        1: y = 16'(t);
        2: y = 16'(t + h - 1);
        default: y = 16'(t + h);
      endcase
    end else if (pick < 85) begin
      x = 16'($urandom_range(0, FB_W - 1));
      y = 16'($urandom_range(0, FB_H - 1));
    end else begin
      case ($urandom_range(0, 3))
        0: begin x = 16'($urandom); y = 16'($urandom); end
        1: begin x = -16'($urandom_range(1, 300)); y = 16'($urandom_range(0, FB_H - 1)); end
        2: begin x = 16'($urandom_range(0, FB_W - 1)); y = 16'(FB_H + $urandom_range(0, 300)); end
        default: begin
          x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          y = 16'($urandom);
        end
      endcase
    end

    pick = $urandom_range(0, 99);
    if (pick < 30) a = ACT_OPAQUE;
    else if (pick < 50) a = ACT_KEYED;
    else if (pick < 78) a = ACT_BLEND;
    else a = ACT_READ;

    if (a == ACT_KEYED && $urandom_range(0, 2) == 0) c = sb.chroma_key;
    if (a == ACT_BLEND) begin
      case ($urandom_range(0, 9))
        0: c[31:24] = 8'h00;
        1: c[31:24] = ALPHA_OPAQUE;
        2: c[31:24] = 8'h01;
        3: c[31:24] = 8'hFE;
        default: ;
      endcase
    end

    // never touch an entry that has not been written yet
    if (a == ACT_READ && !sb.read_defined(x, y)) a = ACT_OPAQUE;
    if (a == ACT_BLEND && c[31:24] != 8'h00 && c[31:24] != ALPHA_OPAQUE &&
        !sb.blend_defined(x, y))
      c[31:24] = ALPHA_OPAQUE;
  endtask

  task automatic phase_config(int ph);
    case (ph)
      1: set_clip(0, 0, 256, 256, 32'hFFFF_FFFF);
      2: set_clip(16, 32, 64, 48, $urandom);
      3: set_clip(255, 255, 256, 256, 32'h0000_0000);      // clip past the surface
      4: set_clip(40, 200, 0, 100, $urandom);               // empty: zero width
      5: set_clip(100, 7, 1, 1, $urandom);                  // single pixel
      6: set_clip(200, 10, 200, 0, $urandom);               // empty: zero height
      7: set_clip($urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 256), $urandom_range(0, 256), $urandom);
      default: ;                                            // reset values
    endcase
  endtask

  task automatic run_random(int ph);
    action_t           a;
    logic signed [15:0] x, y;
    logic [31:0]        c;
    int                 chunk, i;
    hot_x = (int'(sb.clip_left) > FB_W - 6) ? FB_W - 6 : int'(sb.clip_left);
    hot_y = (int'(sb.clip_top) > FB_H - 6) ? FB_H - 6 : int'(sb.clip_top);
    for (chunk = 0; chunk < 4; chunk++) begin
      set_idling((ph + chunk) % 4);
      // long receiver hold-off while the sender keeps offering
      if (ph == 2 && chunk == 0) hold_left = 90;
      // sender pauses until everything outstanding has come back
      if (ph == 1 && chunk == 2) drain();
      for (i = 0; i < CHUNK_OPS; i++) begin
        pace();
        gen_op(a, x, y, c);
        drive_op(a, x, y, c);
      end
    end
  endtask

  initial begin
    int ph;
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    hold_left = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hot_x = 0;
    hot_y = 0;
    item_ch.valid       = 1'b0;
    item_ch.action      = ACT_OPAQUE;
    item_ch.dest_x      = '0;
    item_ch.dest_y      = '0;
    item_ch.pixel_color = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_CLIP_LEFT;
    cfg_ch.data         = '0;
    res_ch.ready        = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: corners, off-surface extremes, clip before key/alpha,
    // key match, alpha 0 / 1 / 254 / 255 and back-to-back read-after-blend.
    op(ACT_OPAQUE, 0, 0, 32'hFFFF_FFFF);
    op(ACT_OPAQUE, 255, 255, 32'h0000_0000);
    op(ACT_READ, 0, 0, 32'h0000_0000);
    op(ACT_READ, 255, 255, 32'hFFFF_FFFF);
    op(ACT_OPAQUE, -1, 0, 32'hDEAD_BEEF);
    op(ACT_OPAQUE, 0, -1, 32'hDEAD_BEEF);
    op(ACT_OPAQUE, 256, 0, 32'hDEAD_BEEF);
    op(ACT_OPAQUE, 0, 256, 32'hDEAD_BEEF);
    op(ACT_BLEND, -32768, 32767, 32'h8012_3456);
    op(ACT_KEYED, 32767, -32768, 32'h0000_0000);
    op(ACT_READ, -1, -1, 32'h0000_0000);
    op(ACT_READ, 32767, 32767, 32'h0000_0000);
    op(ACT_KEYED, 1, 0, 32'h0000_0000);
    op(ACT_KEYED, 1, 0, 32'h1234_5678);
    op(ACT_BLEND, 1, 0, 32'h00AB_CDEF);
    op(ACT_BLEND, 2, 0, 32'hFF00_FF00);
    op(ACT_BLEND, 1, 0, 32'h80FF_FFFF);
    op(ACT_READ, 1, 0, 32'h0000_0000);
    op(ACT_BLEND, 0, 0, 32'h0100_0000);
    op(ACT_BLEND, 255, 255, 32'hFEFF_FFFF);
    op(ACT_BLEND, 255, 255, 32'h7F80_4020);
    op(ACT_READ, 255, 255, 32'h0000_0000);
    op(ACT_READ, 0, 0, 32'h0000_0000);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      phase_config(ph);
      run_random(ph);
      drain();
    end

    // tail: catch any stray result after the last expected one
    repeat (24) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cpbw_pkg.sv
src/cpbw_item_if.sv
src/cpbw_result_if.sv
src/cpbw_cfg_if.sv
src/clipped_pixel_blend_writer.sv
sim/cpbw_scoreboard_pkg.sv
sim/tb_clipped_pixel_blend_writer.sv
